// ----- hw/rtl/srfp_pkg.sv -----
package srfp_pkg;

    // input item kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_REPLY_HEADER       = 2'd0;
    localparam logic [1:0] CFG_MAX_COMMAND_ID     = 2'd1;
    localparam logic [1:0] CFG_MAX_CONTENT_LENGTH = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT_TICKS      = 2'd3;

    localparam logic [15:0] RST_REPLY_HEADER       = 16'd7173;
    localparam logic [7:0]  RST_MAX_COMMAND_ID     = 8'd255;
    localparam logic [7:0]  RST_MAX_CONTENT_LENGTH = 8'd250;
    localparam logic [15:0] RST_TIMEOUT_TICKS      = 16'd100;

    localparam logic RES_CONTENT = 1'b0;
    localparam logic RES_STATUS  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CHECKSUM = 3'd1,
        ST_TOOBIG   = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_TIMEOUT  = 3'd4
    } t_status;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_HEADER   = 6'b000010,
        PH_COMMAND  = 6'b000100,
        PH_LENGTH   = 6'b001000,
        PH_CONTENT  = 6'b010000,
        PH_CHECKSUM = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [15:0] reply_header;
        logic [7:0]  max_command_id;
        logic [7:0]  max_content_length;
        logic [15:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] content_byte;
        logic [7:0] content_index;
        logic [7:0] command_id;
        logic [7:0] content_length;
        logic [2:0] frame_status;
        logic       last;
    } t_result;

endpackage

// ----- hw/rtl/servo_response_frame_parser.sv -----
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_kind, i_rx_byte
// result    out        o_valid / i_stall  o_result_kind .. o_last
// config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// one beat per cycle sustained while no beat waits for the result register; a result goes
// through the input register, then parse logic into the result register
// synchronous active-low reset clears the parser state and loads register defaults
// a beat that gives no result moves on even while a result is held by i_stall;
// a beat that gives a result waits in the input register until the result register frees
module servo_response_frame_parser
    import srfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_content_byte,
    output logic [7:0]  o_content_index,
    output logic [7:0]  o_command_id,
    output logic [7:0]  o_content_length,
    output logic [2:0]  o_frame_status,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg       cfg;
    logic       r_in_valid;
    logic       n_in_valid;
    logic [1:0] r_in_kind;
    logic [7:0] r_in_byte;
    logic       has_result;
    t_result    core_result;
    logic       out_free;
    logic       advance;
    logic       accept;
    t_result    out_result;

    srfp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign advance    = r_in_valid && (!has_result || out_free);
    assign o_stall    = r_in_valid && !advance;
    assign accept     = i_valid && !o_stall;
    assign n_in_valid = accept || (r_in_valid && !advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_rx_byte;
        end
    end

    srfp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_step       (advance),
        .i_kind       (r_in_kind),
        .i_rx_byte    (r_in_byte),
        .o_has_result (has_result),
        .o_result     (core_result)
    );

    srfp_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && has_result),
        .i_result (core_result),
        .i_stall  (i_stall),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_result_kind    = out_result.result_kind;
    assign o_content_byte   = out_result.content_byte;
    assign o_content_index  = out_result.content_index;
    assign o_command_id     = out_result.command_id;
    assign o_content_length = out_result.content_length;
    assign o_frame_status   = out_result.frame_status;
    assign o_last           = out_result.last;

endmodule

// ----- hw/rtl/srfp_cfg.sv -----
module srfp_cfg
    import srfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REPLY_HEADER:       n_cfg.reply_header       = i_cfg_data;
                CFG_MAX_COMMAND_ID:     n_cfg.max_command_id     = i_cfg_data[7:0];
                CFG_MAX_CONTENT_LENGTH: n_cfg.max_content_length = i_cfg_data[7:0];
                CFG_TIMEOUT_TICKS:      n_cfg.timeout_ticks      = i_cfg_data;
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reply_header       <= RST_REPLY_HEADER;
            r_cfg.max_command_id     <= RST_MAX_COMMAND_ID;
            r_cfg.max_content_length <= RST_MAX_CONTENT_LENGTH;
            r_cfg.timeout_ticks      <= RST_TIMEOUT_TICKS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/srfp_core.sv -----
module srfp_core
    import srfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_step,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_rx_byte,
    output logic       o_has_result,
    output t_result    o_result
);

    t_phase      r_phase,          n_phase;
    logic        r_header_low_seen, n_header_low_seen;
    logic [7:0]  r_held_command,   n_held_command;
    logic [7:0]  r_held_length,    n_held_length;
    logic [7:0]  r_bytes_received, n_bytes_received;
    logic [7:0]  r_running_sum,    n_running_sum;
    logic [15:0] r_ticks_left,     n_ticks_left;

    logic        has_result;
    t_result     res;
    logic [7:0]  cnt_inc;
    logic [15:0] ticks_dec;

    assign cnt_inc   = r_bytes_received + 8'd1;
    assign ticks_dec = (r_ticks_left != 16'd0) ? (r_ticks_left - 16'd1) : 16'd0;

    always_comb begin
        n_phase           = r_phase;
        n_header_low_seen = r_header_low_seen;
        n_held_command    = r_held_command;
        n_held_length     = r_held_length;
        n_bytes_received  = r_bytes_received;
        n_running_sum     = r_running_sum;
        n_ticks_left      = r_ticks_left;
        has_result        = 1'b0;
        res               = '0;

        case (i_kind)
            KIND_START: begin
                n_phase           = PH_HEADER;
                n_header_low_seen = 1'b0;
                n_held_command    = 8'd0;
                n_held_length     = 8'd0;
                n_bytes_received  = 8'd0;
                n_running_sum     = 8'd0;
                n_ticks_left      = i_cfg.timeout_ticks;
            end
            KIND_BYTE: begin
                case (r_phase)
                    PH_HEADER: begin
                        if (!r_header_low_seen) begin
                            if (i_rx_byte == i_cfg.reply_header[7:0]) begin
                                n_header_low_seen = 1'b1;
                            end
                        end else begin
                            // a wrong second byte restarts the search, not retried
                            n_header_low_seen = 1'b0;
                            if (i_rx_byte == i_cfg.reply_header[15:8]) begin
                                n_running_sum = i_cfg.reply_header[7:0] + i_rx_byte;
                                n_phase       = PH_COMMAND;
                            end
                        end
                    end
                    PH_COMMAND: begin
                        n_held_command = i_rx_byte;
                        if (i_rx_byte > i_cfg.max_command_id) begin
                            has_result         = 1'b1;
                            res.result_kind    = RES_STATUS;
                            res.frame_status   = ST_UNKNOWN;
                            res.last           = 1'b1;
                            n_phase            = PH_IDLE;
                            n_ticks_left       = 16'd0;
                        end else begin
                            n_running_sum = r_running_sum + i_rx_byte;
                            n_phase       = PH_LENGTH;
                        end
                    end
                    PH_LENGTH: begin
                        n_held_length = i_rx_byte;
                        if (i_rx_byte > i_cfg.max_content_length) begin
                            has_result         = 1'b1;
                            res.result_kind    = RES_STATUS;
                            res.frame_status   = ST_TOOBIG;
                            res.last           = 1'b1;
                            n_phase            = PH_IDLE;
                            n_ticks_left       = 16'd0;
                        end else begin
                            n_running_sum    = r_running_sum + i_rx_byte;
                            n_bytes_received = 8'd0;
                            // zero length skips straight to the checksum
                            n_phase = (i_rx_byte == 8'd0) ? PH_CHECKSUM : PH_CONTENT;
                        end
                    end
                    PH_CONTENT: begin
                        has_result        = 1'b1;
                        res.result_kind   = RES_CONTENT;
                        res.content_byte  = i_rx_byte;
                        res.content_index = r_bytes_received;
                        n_running_sum     = r_running_sum + i_rx_byte;
                        n_bytes_received  = cnt_inc;
                        if (cnt_inc == r_held_length) begin
                            n_phase = PH_CHECKSUM;
                        end
                    end
                    PH_CHECKSUM: begin
                        has_result       = 1'b1;
                        res.result_kind  = RES_STATUS;
                        res.frame_status = (i_rx_byte == r_running_sum) ? ST_OK : ST_CHECKSUM;
                        res.last         = 1'b1;
                        n_phase          = PH_IDLE;
                        n_ticks_left     = 16'd0;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            KIND_TICK: begin
                if (r_phase != PH_IDLE) begin
                    n_ticks_left = ticks_dec;
                    if (ticks_dec == 16'd0) begin
                        has_result       = 1'b1;
                        res.result_kind  = RES_STATUS;
                        res.frame_status = ST_TIMEOUT;
                        res.last         = 1'b1;
                        n_phase          = PH_IDLE;
                    end
                end
            end
            default: begin
                has_result = 1'b0;
            end
        endcase

        res.command_id     = n_held_command;
        res.content_length = n_held_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_header_low_seen <= 1'b0;
            r_held_command    <= 8'd0;
            r_held_length     <= 8'd0;
            r_bytes_received  <= 8'd0;
            r_running_sum     <= 8'd0;
            r_ticks_left      <= 16'd0;
        end else if (i_step) begin
            r_phase           <= n_phase;
            r_header_low_seen <= n_header_low_seen;
            r_held_command    <= n_held_command;
            r_held_length     <= n_held_length;
            r_bytes_received  <= n_bytes_received;
            r_running_sum     <= n_running_sum;
            r_ticks_left      <= n_ticks_left;
        end
    end

    assign o_has_result = has_result;
    assign o_result     = res;

`ifndef SYNTHESIS
    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && has_result && res.last |=> r_phase == PH_IDLE)
        else $error("frame end did not return to idle");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        has_result && res.result_kind == RES_CONTENT |-> res.content_index < r_held_length)
        else $error("content index beyond declared length");

    a_idle_no_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_ticks_left == 16'd0)
        else $error("timeout count left running while idle");
`endif

endmodule

// ----- hw/rtl/srfp_out.sv -----
module srfp_out
    import srfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free  = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- verif/srfp_reply_checker.sv -----
`timescale 1ns / 1ps

module srfp_reply_checker
    import srfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_result_kind,
    input  logic [7:0]  i_content_byte,
    input  logic [7:0]  i_content_index,
    input  logic [7:0]  i_command_id,
    input  logic [7:0]  i_content_length,
    input  logic [2:0]  i_frame_status,
    input  logic        i_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_mismatch_count,
    output int          o_results_due
);

    t_cfg        cfg = '{RST_REPLY_HEADER, RST_MAX_COMMAND_ID, RST_MAX_CONTENT_LENGTH,
                         RST_TIMEOUT_TICKS};
    t_phase      frame_phase = PH_IDLE;
    bit          header_low_seen = 1'b0;
    logic [7:0]  held_command = '0;
    logic [7:0]  held_length = '0;
    logic [7:0]  content_count = '0;
    logic [7:0]  byte_sum = '0;
    logic [15:0] ticks_left = '0;

    t_result     frame_results_due[$];
    int          mismatch_count = 0;
    int          results_due = 0;

    assign o_mismatch_count = mismatch_count;
    assign o_results_due = results_due;

    function automatic void clear_frame();
        header_low_seen = 1'b0;
        held_command = '0;
        held_length = '0;
        content_count = '0;
        byte_sum = '0;
    endfunction

    function automatic t_result close_frame(input t_status status);
        t_result r;
        r = '0;
        r.result_kind = RES_STATUS;
        r.command_id = held_command;
        r.content_length = held_length;
        r.frame_status = status;
        r.last = 1'b1;
        frame_phase = PH_IDLE;
        ticks_left = '0;
        return r;
    endfunction

    task automatic parse_beat(input logic [1:0] kind, input logic [7:0] b,
                              output bit produced, output t_result res);
        produced = 1'b0;
        res = '0;
        if (kind == KIND_START) begin
            clear_frame();
            frame_phase = PH_HEADER;
            ticks_left = cfg.timeout_ticks;
        end else if (frame_phase != PH_IDLE && kind == KIND_BYTE) begin
            case (frame_phase)
                PH_HEADER: begin
                    if (!header_low_seen) begin
                        if (b == cfg.reply_header[7:0])
                            header_low_seen = 1'b1;
                    end else begin
                        // a wrong second byte is not retried as a first byte
                        header_low_seen = 1'b0;
                        if (b == cfg.reply_header[15:8]) begin
                            byte_sum = cfg.reply_header[7:0] + b;
                            frame_phase = PH_COMMAND;
                        end
                    end
                end
                PH_COMMAND: begin
                    held_command = b;
                    if (b > cfg.max_command_id) begin
                        res = close_frame(ST_UNKNOWN);
                        produced = 1'b1;
                    end else begin
                        byte_sum = byte_sum + b;
                        frame_phase = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    held_length = b;
                    if (b > cfg.max_content_length) begin
                        res = close_frame(ST_TOOBIG);
                        produced = 1'b1;
                    end else begin
                        byte_sum = byte_sum + b;
                        content_count = '0;
                        if (b == 8'd0)
                            frame_phase = PH_CHECKSUM;
                        else
                            frame_phase = PH_CONTENT;
                    end
                end
                PH_CONTENT: begin
                    res.result_kind = RES_CONTENT;
                    res.content_byte = b;
                    res.content_index = content_count;
                    res.command_id = held_command;
                    res.content_length = held_length;
                    res.frame_status = ST_OK;
                    res.last = 1'b0;
                    produced = 1'b1;
                    byte_sum = byte_sum + b;
                    content_count = content_count + 8'd1;
                    if (content_count == held_length)
                        frame_phase = PH_CHECKSUM;
                end
                PH_CHECKSUM: begin
                    if (b == byte_sum)
                        res = close_frame(ST_OK);
                    else
                        res = close_frame(ST_CHECKSUM);
                    produced = 1'b1;
                end
                default: ;
            endcase
        end else if (frame_phase != PH_IDLE && kind == KIND_TICK) begin
            if (ticks_left != 16'd0)
                ticks_left = ticks_left - 16'd1;
            if (ticks_left == 16'd0) begin
                res = close_frame(ST_TIMEOUT);
                produced = 1'b1;
            end
        end
    endtask

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result predicted;
        bit      produced;
        if (!i_rst_n) begin
            cfg = '{RST_REPLY_HEADER, RST_MAX_COMMAND_ID, RST_MAX_CONTENT_LENGTH,
                    RST_TIMEOUT_TICKS};
            frame_phase = PH_IDLE;
            ticks_left = '0;
            clear_frame();
            frame_results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (frame_results_due.size() == 0) begin
                    $error("result beat with nothing expected");
                    mismatch_count++;
                end else begin
                    want = frame_results_due.pop_front();
                    check_field("result_kind", want.result_kind, i_result_kind);
                    check_field("content_byte", want.content_byte, i_content_byte);
                    check_field("content_index", want.content_index, i_content_index);
                    check_field("command_id", want.command_id, i_command_id);
                    check_field("content_length", want.content_length, i_content_length);
                    check_field("frame_status", want.frame_status, i_frame_status);
                    check_field("last", want.last, i_last);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REPLY_HEADER:       cfg.reply_header = i_cfg_data;
                    CFG_MAX_COMMAND_ID:     cfg.max_command_id = i_cfg_data[7:0];
                    CFG_MAX_CONTENT_LENGTH: cfg.max_content_length = i_cfg_data[7:0];
                    CFG_TIMEOUT_TICKS:      cfg.timeout_ticks = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                parse_beat(i_kind, i_rx_byte, produced, predicted);
                if (produced)
                    frame_results_due.push_back(predicted);
            end
        end
        results_due = frame_results_due.size();
    end

endmodule

// ----- verif/tb_servo_response_frame_parser.sv -----
`timescale 1ns / 1ps

module tb_servo_response_frame_parser;
    import srfp_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int BEATS_PER_PHASE = 255;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_kind = KIND_TICK;
    logic [7:0]  i_rx_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_result_kind;
    logic [7:0]  o_content_byte;
    logic [7:0]  o_content_index;
    logic [7:0]  o_command_id;
    logic [7:0]  o_content_length;
    logic [2:0]  o_frame_status;
    logic        o_last;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_REPLY_HEADER;
    logic [15:0] i_cfg_data = '0;

    int          mismatch_count;
    int          results_due;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          long_hold = 1'b0;
    int          hold_cycles = 0;
    int          beats_sent = 0;
    int          quiet_cycles = 0;

    // what the parser is currently configured with, for building frames
    logic [15:0] shadow_header = RST_REPLY_HEADER;
    logic [7:0]  shadow_max_cmd = RST_MAX_COMMAND_ID;
    logic [7:0]  shadow_max_len = RST_MAX_CONTENT_LENGTH;

    servo_response_frame_parser u_dut (.*);

    srfp_reply_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_kind           (i_kind),
        .i_rx_byte        (i_rx_byte),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_result_kind    (o_result_kind),
        .i_content_byte   (o_content_byte),
        .i_content_index  (o_content_index),
        .i_command_id     (o_command_id),
        .i_content_length (o_content_length),
        .i_frame_status   (o_frame_status),
        .i_last           (o_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_results_due    (results_due)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver side: random stall, or a long hold-off while long_hold is raised
    always @(negedge i_clk) begin
        if (long_hold && hold_cycles < LONG_HOLD_CYCLES) begin
            i_stall = 1'b1;
            hold_cycles++;
        end else begin
            if (!long_hold)
                hold_cycles = 0;
            i_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [1:0] kind, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_kind = kind;
        i_rx_byte = b;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        i_valid = 1'b0;
        if (kind != KIND_UNUSED)
            beats_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_REPLY_HEADER:       shadow_header = val;
            CFG_MAX_COMMAND_ID:     shadow_max_cmd = val[7:0];
            CFG_MAX_CONTENT_LENGTH: shadow_max_len = val[7:0];
            default: ;
        endcase
    endtask

    // beats with no result may still sit in the pipe, so keep waiting after the last result is seen
    task automatic drain();
        i_valid = 1'b0;
        while (results_due != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_frame(input bit well_formed);
        logic [7:0] frame_bytes[$];
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] chk;
        logic [7:0] b;
        int         mode;
        int         len_pick;
        int         cut;
        mode = well_formed ? 99 : $urandom_range(99);
        if ($urandom_range(9) == 0)
            cmd = 8'($urandom_range(255));
        else
            cmd = 8'($urandom_range(shadow_max_cmd));
        len_pick = $urandom_range(39);
        if (len_pick == 0)
            len = 8'($urandom_range(255));
        else if (len_pick == 1)
            len = shadow_max_len;
        else
            len = 8'($urandom_range((shadow_max_len < 8'd6) ? shadow_max_len : 6));
        if (mode < 5) begin
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(255)));
        end else if (mode < 10) begin
            // header low byte then a likely wrong second byte
            frame_bytes.push_back(shadow_header[7:0]);
            frame_bytes.push_back(8'($urandom_range(255)));
        end
        frame_bytes.push_back(shadow_header[7:0]);
        frame_bytes.push_back(shadow_header[15:8]);
        frame_bytes.push_back(cmd);
        frame_bytes.push_back(len);
        chk = shadow_header[7:0] + shadow_header[15:8] + cmd + len;
        for (int k = 0; k < len; k++) begin
            b = 8'($urandom_range(255));
            frame_bytes.push_back(b);
            chk = chk + b;
        end
        if (mode >= 10 && mode < 18)
            chk = chk ^ (8'h01 << $urandom_range(7));
        frame_bytes.push_back(chk);
        cut = frame_bytes.size();
        if (mode >= 18 && mode < 24)
            cut = $urandom_range(frame_bytes.size() - 1);
        send_beat(KIND_START, 8'($urandom_range(255)));
        for (int k = 0; k < cut; k++) begin
            if ($urandom_range(99) < 6)
                send_beat(KIND_TICK, 8'($urandom_range(255)));
            send_beat(KIND_BYTE, frame_bytes[k]);
        end
        if (mode >= 24 && mode < 30) begin
            repeat ($urandom_range(1, 4))
                send_beat(2'($urandom_range(3)), 8'($urandom_range(255)));
        end
    endtask

    initial begin
        logic [7:0] hdr_lo;
        logic [7:0] hdr_hi;
        logic [7:0] chk;
        int         target;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed beats on the reset configuration, then with a lower command limit and timeout
        hdr_lo = shadow_header[7:0];
        hdr_hi = shadow_header[15:8];
        send_beat(KIND_BYTE, 8'hFF);      // not armed, dropped
        send_beat(KIND_TICK, 8'h00);
        send_beat(KIND_UNUSED, 8'hAA);
        send_beat(KIND_START, 8'h55);
        send_beat(KIND_BYTE, 8'h00);      // wrong first header byte
        send_beat(KIND_BYTE, hdr_lo);
        send_beat(KIND_BYTE, 8'h00);      // wrong second byte restarts search
        send_beat(KIND_BYTE, hdr_lo);
        send_beat(KIND_BYTE, hdr_hi);
        send_beat(KIND_BYTE, 8'hFF);      // command id at the limit
        send_beat(KIND_BYTE, 8'h00);      // zero length, straight to checksum
        chk = hdr_lo + hdr_hi + 8'hFF;
        send_beat(KIND_BYTE, chk);
        send_beat(KIND_START, 8'hFF);
        send_beat(KIND_BYTE, hdr_lo);
        send_beat(KIND_BYTE, hdr_hi);
        send_beat(KIND_BYTE, 8'h00);
        send_beat(KIND_BYTE, 8'hFB);      // length above the limit
        send_beat(KIND_START, 8'h00);
        send_beat(KIND_BYTE, hdr_lo);
        send_beat(KIND_BYTE, hdr_hi);
        send_beat(KIND_START, 8'h3C);     // rearm in the middle of a frame
        send_beat(KIND_BYTE, hdr_lo);
        send_beat(KIND_BYTE, hdr_hi);
        send_beat(KIND_BYTE, 8'h01);
        send_beat(KIND_BYTE, 8'h01);
        send_beat(KIND_BYTE, 8'hFF);
        send_beat(KIND_BYTE, 8'h00);      // bad checksum
        drain();
        write_reg(CFG_MAX_COMMAND_ID, 16'h0010);
        write_reg(CFG_TIMEOUT_TICKS, 16'd1);
        send_beat(KIND_START, 8'hC3);
        send_beat(KIND_BYTE, hdr_lo);
        send_beat(KIND_BYTE, hdr_hi);
        send_beat(KIND_BYTE, 8'h11);      // unknown command
        send_beat(KIND_START, 8'h00);
        send_beat(KIND_TICK, 8'hFF);      // times out on the first tick

        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: begin
                    write_reg(CFG_REPLY_HEADER, 16'h0000);
                    write_reg(CFG_MAX_COMMAND_ID, 16'h00FF);
                    write_reg(CFG_MAX_CONTENT_LENGTH, 16'h00FF);
                    write_reg(CFG_TIMEOUT_TICKS, 16'hFFFF);
                end
                1: begin
                    write_reg(CFG_REPLY_HEADER, 16'hFFFF);
                    write_reg(CFG_MAX_COMMAND_ID, 16'h0000);
                    write_reg(CFG_MAX_CONTENT_LENGTH, 16'h0000);
                    write_reg(CFG_TIMEOUT_TICKS, 16'd1);
                end
                default: begin
                    write_reg(CFG_REPLY_HEADER, 16'($urandom_range(16'hFFFF)));
                    write_reg(CFG_MAX_COMMAND_ID, 16'($urandom_range(100, 255)));
                    write_reg(CFG_MAX_CONTENT_LENGTH, 16'($urandom_range(4, 255)));
                    if (p % 2 == 1)
                        write_reg(CFG_TIMEOUT_TICKS, 16'($urandom_range(1, 40)));
                    else
                        write_reg(CFG_TIMEOUT_TICKS, 16'($urandom_range(41, 65535)));
                end
            endcase
            send_idle_pct = (p < 2) ? 21 : (p < 4) ? 77 : 0;
            recv_idle_pct = (p < 2) ? 77 : (p < 4) ? 21 : 0;
            target = beats_sent + BEATS_PER_PHASE;
            if (p == 4) begin
                // receiver holds off while frames keep coming, so the parser backs up
                long_hold = 1'b1;
                repeat (4) send_frame(1'b1);
                long_hold = 1'b0;
            end
            while (beats_sent < target)
                send_frame(1'b0);
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/srfp_pkg.sv
hw/rtl/srfp_cfg.sv
hw/rtl/srfp_core.sv
hw/rtl/srfp_out.sv
hw/rtl/servo_response_frame_parser.sv
verif/srfp_reply_checker.sv
verif/tb_servo_response_frame_parser.sv
